@@ hw/rtl/ssp_pkg.sv @@
// Shared types and constants for the song stream parser.
// No dependencies; used by every module of the block.
package ssp_pkg;

    // result kinds
    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_CHANBYTE = 3'd1;
    localparam logic [2:0] KIND_DELAY    = 3'd2;
    localparam logic [2:0] KIND_NOTE     = 3'd3;
    localparam logic [2:0] KIND_RESERVED = 3'd4;
    localparam logic [2:0] KIND_END      = 3'd5;
    localparam logic [2:0] KIND_ERROR    = 3'd6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_stream;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  channel_id;
        logic [7:0]  master_level;
        logic [7:0]  channel_mode;
        logic [23:0] wide_value;
        logic [7:0]  data_byte;
        logic [12:0] delay_ticks;
        logic [6:0]  note_id;
        logic [6:0]  velocity;
        logic [14:0] duration;
        logic [1:0]  reserved_length;
        logic        last_of_run;
    } out_t;

    // one queued request: the primary result and whether an end follows it
    typedef struct packed {
        out_t res;
        logic add_end;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } push_t;

endpackage

@@ hw/rtl/ssp_front.sv @@
// Front end: takes one byte per accepted request, tracks the file layout
// and emits at most one queue entry per byte. Depends on ssp_pkg.
module ssp_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  ssp_pkg::in_t   in_data,
    output ssp_pkg::push_t push_out
);

    typedef enum logic [2:0] {
        ST_SIG, ST_CHAN, ST_PAY, ST_EVT, ST_END, ST_ERR
    } stage_t;

    localparam logic [31:0] SIG_WORD = 32'h0045_4753;

    stage_t      stage_reg, stage_next;
    logic [2:0]  idx_reg, idx_next;
    logic [47:0] hs_reg, hs_next;
    logic [23:0] rem_reg, rem_next;
    logic [7:0]  lead_reg, lead_next;
    logic [7:0]  first_reg, first_next;

    logic [7:0]  b;
    logic        eos;
    logic [2:0]  idx_inc;
    logic [47:0] hs_shift;
    logic [7:0]  sig_byte;
    logic [1:0]  extra_b, extra_lead;
    logic        give_err, give_prim, end_req;
    ssp_pkg::out_t prim;
    logic [6:0]  d_inc;
    logic [5:0]  dur_inc;
    logic [6:0]  vel_raw, vel_q, vel;

    // bytes after a lead: 0..2, or 3 for a lead with no meaning
    function automatic logic [1:0] lead_extra(input logic [7:0] lead);
        logic [1:0] r;
        case (lead[7:4])
            4'h8, 4'h9, 4'hA: r = 2'd2;
            4'hB:             r = 2'd0;
            4'hC:             r = 2'd1;
            4'hD, 4'hE:       r = 2'd2;
            default:          r = 2'd3;
        endcase
        return r;
    endfunction

    assign b        = in_data.byte_value;
    assign eos      = in_data.end_of_stream;
    assign idx_inc  = idx_reg + 3'd1;
    assign hs_shift = {hs_reg[39:0], b};
    assign sig_byte = SIG_WORD[{~idx_reg[1:0], 3'b000} +: 8];
    assign extra_b  = lead_extra(b);
    assign extra_lead = lead_extra(lead_reg);
    assign d_inc    = {1'b0, b[5:0]} + 7'd1;
    assign dur_inc  = {1'b0, b[4:0]} + 6'd1;
    assign vel_raw  = {first_reg[0], b[7:2]};
    assign vel_q    = {vel_raw[6:3], vel_raw[6:4]};

    always_comb begin
        stage_next = stage_reg;
        idx_next   = idx_reg;
        hs_next    = hs_reg;
        rem_next   = rem_reg;
        lead_next  = lead_reg;
        first_next = first_reg;
        give_err   = 1'b0;
        give_prim  = 1'b0;
        end_req    = 1'b0;
        prim       = '0;
        vel        = (lead_reg[7:4] == 4'h8) ? vel_raw : vel_q;

        case (stage_reg)
            ST_SIG: begin
                if (b != sig_byte) begin
                    give_err = 1'b1;
                end else if (idx_inc == 3'd4) begin
                    stage_next = ST_CHAN;
                    idx_next   = 3'd0;
                    end_req    = eos;
                end else begin
                    idx_next = idx_inc;
                    give_err = eos;
                end
            end
            ST_CHAN: begin
                if (idx_reg == 3'd0 && b == 8'hFF) begin
                    stage_next = ST_EVT;
                    end_req    = eos;
                end else begin
                    hs_next = hs_shift;
                    if (idx_inc < 3'd6) begin
                        idx_next = idx_inc;
                        give_err = eos;
                    end else begin
                        idx_next = 3'd0;
                        if (eos && hs_shift[23:0] != 24'd0) begin
                            give_err = 1'b1;
                        end else begin
                            give_prim          = 1'b1;
                            prim.kind          = ssp_pkg::KIND_HEADER;
                            prim.channel_id    = hs_shift[47:40];
                            prim.master_level  = hs_shift[39:32];
                            prim.channel_mode  = hs_shift[31:24];
                            prim.wide_value    = hs_shift[23:0];
                            rem_next           = hs_shift[23:0];
                            stage_next = (hs_shift[23:0] != 24'd0) ? ST_PAY : ST_CHAN;
                            end_req    = eos;
                        end
                    end
                end
            end
            ST_PAY: begin
                if (eos && rem_reg != 24'd1) begin
                    give_err = 1'b1;
                end else begin
                    give_prim      = 1'b1;
                    prim.kind      = ssp_pkg::KIND_CHANBYTE;
                    prim.data_byte = b;
                    rem_next       = rem_reg - 24'd1;
                    if (rem_reg == 24'd1) begin
                        stage_next = ST_CHAN;
                        idx_next   = 3'd0;
                        end_req    = eos;
                    end
                end
            end
            ST_EVT: begin
                if (idx_reg == 3'd0) begin
                    if (b == 8'h00) begin
                        end_req = 1'b1;
                    end else if (!b[7]) begin
                        give_prim   = 1'b1;
                        prim.kind   = ssp_pkg::KIND_DELAY;
                        prim.delay_ticks = b[6] ? {d_inc, 6'b0} : {7'b0, b[5:0]};
                        end_req     = eos;
                    end else if (extra_b == 2'd3) begin
                        give_err = 1'b1;
                    end else if (extra_b == 2'd0) begin
                        give_prim            = 1'b1;
                        prim.kind            = ssp_pkg::KIND_RESERVED;
                        prim.wide_value      = {16'b0, b};
                        prim.reserved_length = 2'd1;
                        end_req              = eos;
                    end else begin
                        lead_next = b;
                        idx_next  = 3'd1;
                        give_err  = eos;
                    end
                end else if (extra_lead == 2'd3 || extra_lead == 2'd0) begin
                    give_err = 1'b1;
                end else if (idx_reg == 3'd1) begin
                    first_next = b;
                    if (extra_lead == 2'd1) begin
                        give_prim            = 1'b1;
                        prim.kind            = ssp_pkg::KIND_RESERVED;
                        prim.wide_value      = {8'b0, lead_reg, b};
                        prim.reserved_length = 2'd2;
                        idx_next             = 3'd0;
                        end_req              = eos;
                    end else begin
                        idx_next = 3'd2;
                        give_err = eos;
                    end
                end else begin
                    give_prim = 1'b1;
                    idx_next  = 3'd0;
                    end_req   = eos;
                    case (lead_reg[7:4])
                        4'h8, 4'h9, 4'hA: begin
                            prim.kind       = ssp_pkg::KIND_NOTE;
                            prim.channel_id = {4'b0, lead_reg[3:0]};
                            prim.note_id    = first_reg[7:1];
                            prim.velocity   = (vel == 7'd0) ? 7'd1 : vel;
                            case (lead_reg[7:4])
                                4'h8:    prim.duration = {9'b0, b[1:0], 4'b0};
                                4'h9:    prim.duration = {3'b0, dur_inc, 6'b0};
                                default: prim.duration = {dur_inc, 9'b0};
                            endcase
                        end
                        default: begin
                            prim.kind            = ssp_pkg::KIND_RESERVED;
                            prim.wide_value      = {lead_reg, first_reg, b};
                            prim.reserved_length = 2'd3;
                        end
                    endcase
                end
            end
            ST_END: begin
            end
            default: begin
                give_err = 1'b1;
            end
        endcase

        push_out = '0;
        if (give_err) begin
            stage_next              = ST_ERR;
            idx_next                = 3'd0;
            push_out.push           = accept;
            push_out.entry.res.kind = ssp_pkg::KIND_ERROR;
        end else if (give_prim) begin
            push_out.push          = accept;
            push_out.entry.res     = prim;
            push_out.entry.add_end = end_req;
        end else if (end_req) begin
            push_out.push           = accept;
            push_out.entry.res.kind = ssp_pkg::KIND_END;
        end
        if (!give_err && end_req) begin
            stage_next = ST_END;
            idx_next   = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= ST_SIG;
            idx_reg   <= 3'd0;
        end else if (accept) begin
            stage_reg <= stage_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hs_reg    <= hs_next;
            rem_reg   <= rem_next;
            lead_reg  <= lead_next;
            first_reg <= first_next;
        end
    end

endmodule

@@ hw/rtl/ssp_queue.sv @@
// Short queue between the front and back ends.
// Depends on ssp_pkg.
module ssp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  ssp_pkg::push_t  push_in,
    output logic            full,
    output logic            q_valid,
    output ssp_pkg::entry_t q_entry,
    input  logic            pop
);

    ssp_pkg::entry_t mem [ssp_pkg::QUEUE_DEPTH];

    logic [ssp_pkg::QPTR_W-1:0] wr_reg, rd_reg;
    logic [ssp_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                       do_pop;

    assign full    = (cnt_reg == ssp_pkg::QCNT_W'(ssp_pkg::QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_entry = mem[rd_reg];
    assign do_pop  = pop && q_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (push_in.push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push_in.push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push_in.push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_in.push) begin
            mem[wr_reg] <= push_in.entry;
        end
    end

endmodule

@@ hw/rtl/ssp_back.sv @@
// Back end: drains the queue into the output register, appending the
// trailing end result where an entry asks for one. Depends on ssp_pkg.
module ssp_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  ssp_pkg::entry_t q_entry,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output ssp_pkg::out_t   m_payload
);

    logic          valid_reg, valid_next;
    logic          pend_reg, pend_next;
    ssp_pkg::out_t out_reg, out_next;
    logic          load;

    assign load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        out_next   = out_reg;
        pop        = 1'b0;
        if (load) begin
            if (pend_reg) begin
                out_next             = '0;
                out_next.kind        = ssp_pkg::KIND_END;
                out_next.last_of_run = 1'b1;
                valid_next           = 1'b1;
                pend_next            = 1'b0;
            end else if (q_valid) begin
                pop                  = 1'b1;
                out_next             = q_entry.res;
                out_next.last_of_run = !q_entry.add_end;
                pend_next            = q_entry.add_end;
                valid_next           = 1'b1;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid   = valid_reg;
    assign m_payload = out_reg;

endmodule

@@ hw/rtl/synth_song_stream_parser_unit.sv @@
// Top level of the song stream parser.
// Depends on ssp_pkg, ssp_front, ssp_queue and ssp_back.
//
// Usage:
//   s_ channel: one file byte per request, with end_of_stream flagging the
//   last byte. m_ channel: parsed results (headers, payload bytes, delays,
//   notes, reserved events, end, error); a byte yields zero, one or two.
//   last_of_run marks the final result a byte produced.
// Order: the queue slot is written at the edge that accepts the byte and
//   the output register loads from it once that register is free and the
//   entries ahead of it have left. A trailing end result is loaded into the
//   output register after its partner has been taken.
// Throughput: one byte per cycle while the queue has a free slot. A byte
//   that yields two results holds the output register for both in turn, so
//   it sets the rate at one result per cycle while results are taken.
// Front end parses and pushes into a four-entry queue; s_ready drops only
//   when that queue is full, so a stalled receiver backs up into the queue
//   before the sender sees it.
// Reset (aresetn low, synchronous): parser back to the signature check,
//   queue and output register emptied. After an end result nothing more is
//   produced; after an error every further byte gives another error.
module synth_song_stream_parser_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ssp_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output ssp_pkg::out_t m_payload
);

    ssp_pkg::push_t  push;
    ssp_pkg::entry_t q_entry;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic            accept;

    // input takes a request whenever the queue has a free slot
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    ssp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_data  (s_payload),
        .push_out (push)
    );

    ssp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_in (push),
        .full    (q_full),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (q_pop)
    );

    ssp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .pop       (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

@@ hw/rtl/ssp_checker.sv @@
// Port-level checks for the song stream parser, bound to the top level.
// Depends on ssp_pkg.
module ssp_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input ssp_pkg::in_t  s_payload,
    input logic          m_valid,
    input logic          m_ready,
    input ssp_pkg::out_t m_payload
);

    // waiting request holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_payload))
        else $error("request changed while waiting");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // end and error always close a byte's run with empty fields
    a_term: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.kind == ssp_pkg::KIND_END ||
                    m_payload.kind == ssp_pkg::KIND_ERROR)
        |-> m_payload.last_of_run && m_payload.velocity == 7'd0 &&
            m_payload.wide_value == 24'd0 && m_payload.channel_id == 8'd0)
        else $error("malformed end or error result");

    // note velocity never zero
    a_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.kind == ssp_pkg::KIND_NOTE |-> m_payload.velocity != 7'd0)
        else $error("note with zero velocity");

    // nothing follows a delivered end
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_payload.kind == ssp_pkg::KIND_END |=> !m_valid)
        else $error("result after end");

endmodule

bind synth_song_stream_parser_unit ssp_checker u_ssp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
